>>> rtl/r2b_pkg.sv
// Shared constants, types and byte-lookup functions for the image-to-BMP writer.
// No dependencies; imported by the top level, r2b_check and the testbench.
package r2b_pkg;

   localparam int unsigned STORE_BYTES = 1048576;
   localparam int ADDR_W = $clog2(STORE_BYTES);
   // column / offset counters hold up to about 3*STORE_BYTES
   localparam int CW = ADDR_W + 3;
   localparam int SEEN_W = 40;
   localparam int HEAD_BYTES = 36;
   localparam int MIN_FILE = 38;
   localparam int BMP_HDR = 54;

   localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};
   localparam logic [31:0] MAGIC_WORD = 32'h4646_4943;  // "CIFF", first byte low

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_MAGIC     = 3'd2;
   localparam logic [2:0] ST_HDR_FILE  = 3'd3;
   localparam logic [2:0] ST_TOTAL     = 3'd4;
   localparam logic [2:0] ST_CONTENT   = 3'd5;
   localparam logic [2:0] ST_TOO_LARGE = 3'd6;
   localparam logic [2:0] ST_NOT_LOAD  = 3'd7;

   localparam logic [0:0] FUNC_LOAD = 1'b0;
   localparam logic [0:0] FUNC_EMIT = 1'b1;

   typedef struct packed {
      logic [2:0]    status;
      logic [31:0]   total;
      logic [31:0]   img_size;
      logic [CW-1:0] w3;
      logic [CW-1:0] stride;
      logic [CW-1:0] base0;
   } chk_result_type;

   function automatic logic [7:0] bmp_hdr_byte(input logic [5:0] pos, input logic [31:0] total,
                                                input logic [31:0] w, input logic [31:0] h,
                                                input logic [31:0] img);
      logic [7:0] b;
      b = 8'h00;
      case (pos)
         6'd0:  b = 8'h42;
         6'd1:  b = 8'h4d;
         6'd2:  b = total[7:0];
         6'd3:  b = total[15:8];
         6'd4:  b = total[23:16];
         6'd5:  b = total[31:24];
         6'd10: b = 8'd54;
         6'd14: b = 8'd40;
         6'd18: b = w[7:0];
         6'd19: b = w[15:8];
         6'd20: b = w[23:16];
         6'd21: b = w[31:24];
         6'd22: b = h[7:0];
         6'd23: b = h[15:8];
         6'd24: b = h[23:16];
         6'd25: b = h[31:24];
         6'd26: b = 8'd1;
         6'd28: b = 8'd24;
         6'd34: b = img[7:0];
         6'd35: b = img[15:8];
         6'd36: b = img[23:16];
         6'd37: b = img[31:24];
         6'd38: b = 8'h13;   // 2835 px/m
         6'd39: b = 8'h0b;
         6'd42: b = 8'h13;
         6'd43: b = 8'h0b;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // byte of the file head, rebuilt from the magic bytes and the four header words
   function automatic logic [7:0] head_byte(input logic [5:0] idx, input logic [31:0] magic,
                                            input logic [63:0] hdr, input logic [63:0] body,
                                            input logic [63:0] w, input logic [63:0] h);
      logic [5:0] rel;
      logic [7:0] b;
      rel = idx - 6'd4;
      b = 8'h00;
      if (idx < 6'd4) begin
         b = magic[{idx[1:0], 3'b000} +: 8];
      end else begin
         case (rel[4:3])
            2'd0: b = hdr[{rel[2:0], 3'b000} +: 8];
            2'd1: b = body[{rel[2:0], 3'b000} +: 8];
            2'd2: b = w[{rel[2:0], 3'b000} +: 8];
            default: b = h[{rel[2:0], 3'b000} +: 8];
         endcase
      end
      return b;
   endfunction

endpackage

>>> rtl/rgb_image_to_bmp_writer.sv
// Top level of the image-file to 24-bit BMP writer: load parser, pixel store, BMP emitter.
// Depends on r2b_pkg, r2b_ram, r2b_check.
//
//   channel | ports                                        | direction
//   req     | req_valid/req_ready, func, data_byte, last    | in
//   rsp     | rsp_valid/rsp_ready, out_byte, out_last, stat | out
//
// Load bytes use the single pixel-store write port and can be taken back to back. Header,
// padding and error bytes go straight to the output register; a BMP byte read from the
// pixel store passes the registered read first. After the final file byte the check
// sequencer runs its 64-step size product with req_ready low. Reset needs no clearing
// pass. A stalled rsp holds req_ready low only while the output register is full.
module rgb_image_to_bmp_writer
   import r2b_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic [2:0] rsp_status
);

   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [63:0]       hdr_ff, hdr_in, body_ff, body_in, wid_ff, wid_in, hgt_ff, hgt_in;
   logic [31:0]       magic_ff, magic_in;
   logic              mgood_ff, mgood_in;
   logic [2:0]        status_ff, status_in;
   logic              chk_start_ff, chk_start_in;
   logic [SEEN_W:0]   fsize_ff, fsize_in;

   logic [31:0]       pos_ff, pos_in;
   logic [CW-1:0]     col_ff, col_in, pb_ff, pb_in, rb_ff, rb_in;
   logic [1:0]        m_ff, m_in;

   logic              rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic [2:0]        rsp_stat_ff, rsp_stat_in;
   logic              rd_pend_ff, rd_pend_in, rd_last_ff, rd_last_in;

   logic              chk_busy, chk_done;
   chk_result_type    chk;

   logic              acc, acc_load, acc_emit;
   logic [63:0]       diff;
   logic              wr_en;
   logic [5:0]        p6, bsel;
   logic [CW-1:0]     k;
   logic [6:0]        abs7;
   logic              abs_small, is_pix, in_img, last_pos, need_rd;
   logic [7:0]        ram_q, emit_byte;

   assign req_ready = !chk_busy && !chk_start_ff && !rd_pend_ff && (!rsp_valid_ff || rsp_ready);
   assign acc      = req_valid && req_ready;
   assign acc_load = acc && (req_func == FUNC_LOAD);
   assign acc_emit = acc && (req_func == FUNC_EMIT);

   // load side: file head capture and pixel store write
   assign diff  = 64'(seen_ff) - hdr_ff;
   assign wr_en = acc_load && (seen_ff >= SEEN_W'(HEAD_BYTES)) && (64'(seen_ff) >= hdr_ff)
                  && (diff < 64'(STORE_BYTES));
   assign p6    = seen_ff[5:0];
   assign bsel  = p6 - 6'd4;

   always_comb begin
      seen_in = seen_ff; hdr_in = hdr_ff; body_in = body_ff; wid_in = wid_ff; hgt_in = hgt_ff;
      magic_in = magic_ff; mgood_in = mgood_ff; status_in = status_ff;
      chk_start_in = 1'b0; fsize_in = fsize_ff;
      if (acc_load) begin
         if (seen_ff == '0) begin
            hdr_in = '0; body_in = '0; wid_in = '0; hgt_in = '0; magic_in = '0;
            mgood_in = 1'b1;
            status_in = ST_NOT_LOAD;
         end
         if (seen_ff < SEEN_W'(HEAD_BYTES)) begin
            if (seen_ff < SEEN_W'(4)) begin
               magic_in[{p6[1:0], 3'b000} +: 8] = req_data_byte;
               if (req_data_byte != MAGIC_WORD[{p6[1:0], 3'b000} +: 8]) begin
                  mgood_in = 1'b0;
               end
            end else begin
               case (bsel[4:3])
                  2'd0: hdr_in[{bsel[2:0], 3'b000} +: 8]  = req_data_byte;
                  2'd1: body_in[{bsel[2:0], 3'b000} +: 8] = req_data_byte;
                  2'd2: wid_in[{bsel[2:0], 3'b000} +: 8]  = req_data_byte;
                  default: hgt_in[{bsel[2:0], 3'b000} +: 8] = req_data_byte;
               endcase
            end
         end
         if (req_last_byte) begin
            fsize_in = (SEEN_W+1)'(seen_ff) + (SEEN_W+1)'(1);
            chk_start_in = 1'b1;
            seen_in = '0;
         end else if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + SEEN_W'(1);
         end
      end
      if (chk_done) begin
         status_in = chk.status;
      end
   end

   r2b_check u_check (
      .clock      (clock),
      .reset      (reset),
      .start      (chk_start_ff),
      .file_size  (fsize_ff),
      .hdr_size   (hdr_ff),
      .body_size  (body_ff),
      .img_width  (wid_ff),
      .img_height (hgt_ff),
      .magic_good (mgood_ff),
      .busy       (chk_busy),
      .done       (chk_done),
      .res        (chk)
   );

   // emit side: position, column and source-row offset counters
   assign k         = rb_ff + pb_ff + CW'(2) - CW'(m_ff);
   assign abs7      = 7'(hdr_ff[5:0]) + 7'(k[5:0]);
   assign abs_small = (hdr_ff < 64'(HEAD_BYTES)) && (k < CW'(HEAD_BYTES))
                      && (abs7 < 7'(HEAD_BYTES));
   assign is_pix    = pos_ff >= 32'(BMP_HDR);
   assign in_img    = col_ff < chk.w3;
   assign last_pos  = (pos_ff + 32'd1) == chk.total;
   assign need_rd   = is_pix && in_img && !abs_small;

   always_comb begin
      if (!is_pix) begin
         emit_byte = bmp_hdr_byte(pos_ff[5:0], chk.total, wid_ff[31:0], hgt_ff[31:0],
                                  chk.img_size);
      end else if (in_img) begin
         emit_byte = head_byte(abs7[5:0], magic_ff, hdr_ff, body_ff, wid_ff, hgt_ff);
      end else begin
         emit_byte = 8'h00;
      end
   end

   r2b_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (diff[ADDR_W-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (acc_emit && status_ff == ST_OK && need_rd),
      .rd_addr (k[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   always_comb begin
      pos_in = pos_ff; col_in = col_ff; pb_in = pb_ff; rb_in = rb_ff; m_in = m_ff;
      rsp_valid_in = rsp_valid_ff; rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff; rsp_stat_in = rsp_stat_ff;
      rd_pend_in = 1'b0; rd_last_in = rd_last_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (chk_done || (acc_load && seen_ff == '0)) begin
         pos_in = '0; col_in = '0; pb_in = '0; m_in = '0; rb_in = chk.base0;
      end
      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = ram_q;
         rsp_last_in  = rd_last_ff;
         rsp_stat_in  = ST_OK;
      end else if (acc_emit) begin
         if (status_ff != ST_OK) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = 8'h00;
            rsp_last_in  = 1'b1;
            rsp_stat_in  = status_ff;
         end else begin
            if (need_rd) begin
               rd_pend_in = 1'b1;
               rd_last_in = last_pos;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = emit_byte;
               rsp_last_in  = last_pos;
               rsp_stat_in  = ST_OK;
            end
            if (last_pos) begin
               pos_in = '0; col_in = '0; pb_in = '0; m_in = '0; rb_in = chk.base0;
            end else begin
               pos_in = pos_ff + 32'd1;
               if (is_pix) begin
                  if (col_ff == chk.stride - CW'(1)) begin
                     col_in = '0; pb_in = '0; m_in = '0;
                     rb_in  = rb_ff - chk.w3;
                  end else begin
                     col_in = col_ff + CW'(1);
                     if (m_ff == 2'd2) begin
                        m_in  = 2'd0;
                        pb_in = pb_ff + CW'(3);
                     end else begin
                        m_in = m_ff + 2'd1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         status_ff    <= ST_NOT_LOAD;
         mgood_ff     <= 1'b1;
         chk_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         pos_ff       <= '0;
         col_ff       <= '0;
         pb_ff        <= '0;
         m_ff         <= '0;
         hdr_ff       <= '0;
         body_ff      <= '0;
         wid_ff       <= '0;
         hgt_ff       <= '0;
      end else begin
         seen_ff      <= seen_in;
         status_ff    <= status_in;
         mgood_ff     <= mgood_in;
         chk_start_ff <= chk_start_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         pos_ff       <= pos_in;
         col_ff       <= col_in;
         pb_ff        <= pb_in;
         m_ff         <= m_in;
         hdr_ff       <= hdr_in;
         body_ff      <= body_in;
         wid_ff       <= wid_in;
         hgt_ff       <= hgt_in;
      end
      magic_ff    <= magic_in;
      fsize_ff    <= fsize_in;
      rb_ff       <= rb_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_stat_ff <= rsp_stat_in;
      rd_last_ff  <= rd_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;
   assign rsp_status   = rsp_stat_ff;

`ifndef SYNTH
   a_read_returns: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> rsp_valid_ff) else $error("store read lost");
   a_pend_empty_out: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !rsp_valid_ff) else $error("store read into full output");
   a_no_accept_checking: assert property (@(posedge clock) disable iff (reset)
      chk_busy |-> !req_ready) else $error("transaction taken during check");
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stat_ff != ST_OK) |-> (rsp_last_ff && rsp_byte_ff == 8'h00))
      else $error("bad error transaction");
`endif

endmodule

>>> rtl/r2b_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module r2b_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/r2b_check.sv
// File check sequencer: size/magic checks, bit-serial 64x64 size product, BMP sizes.
// Depends on r2b_pkg.
module r2b_check
   import r2b_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SEEN_W:0]   file_size,
   input  logic [63:0]       hdr_size,
   input  logic [63:0]       body_size,
   input  logic [63:0]       img_width,
   input  logic [63:0]       img_height,
   input  logic              magic_good,
   output logic              busy,
   output logic              done,
   output chk_result_type    res
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUM  = 3'd1;
   localparam logic [2:0] S_H3   = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;
   localparam logic [2:0] S_PROD = 3'd5;

   localparam logic [63:0] STORE64 = 64'(STORE_BYTES);

   logic [2:0]     state_ff, state_in;
   logic           done_ff, done_in;
   logic           c1_ff, c1_in, c3_ff, c3_in, c4_ff, c4_in, c5a_ff, c5a_in;
   logic [64:0]    sum_ff, sum_in;
   logic [65:0]    h3_ff, h3_in;
   logic [63:0]    acc_ff, acc_in;
   logic           ovf_ff, ovf_in;
   logic [5:0]     bit_ff, bit_in;
   chk_result_type res_ff, res_in;

   logic [64:0]    dbl;
   logic [64:0]    add;
   logic [63:0]    fsz64;
   logic           c5, c6, wz;
   logic [CW-1:0]  w3;
   logic [CW-1:0]  st4;
   logic [CW+ADDR_W:0]       pix_prod;
   logic [2*ADDR_W+1:0]      wh_prod;

   assign fsz64 = 64'(file_size);
   assign wz    = (img_width == 64'd0) || (img_height == 64'd0);

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      c1_in = c1_ff; c3_in = c3_ff; c4_in = c4_ff; c5a_in = c5a_ff;
      sum_in = sum_ff; h3_in = h3_ff; acc_in = acc_ff; ovf_in = ovf_ff; bit_in = bit_ff;
      res_in = res_ff;
      dbl = {acc_ff, 1'b0};
      add = 65'(dbl[63:0]) + (img_width[bit_ff] ? 65'(h3_ff[63:0]) : 65'd0);
      c5 = wz ? (body_size != 64'd0) : (c5a_ff || ovf_ff || (acc_ff != body_size));
      c6 = (body_size > STORE64) || (img_width > STORE64) || (img_height > STORE64);
      w3 = CW'({img_width[ADDR_W:0], 1'b0}) + CW'(img_width[ADDR_W:0]);
      st4 = CW'(res_ff.w3 + CW'(3)) & ~CW'(3);
      pix_prod = res_ff.stride * img_height[ADDR_W:0];
      wh_prod  = img_width[ADDR_W:0] * img_height[ADDR_W:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            c1_in  = fsz64 < 64'(MIN_FILE);
            c3_in  = hdr_size > fsz64;
            sum_in = 65'(hdr_size) + 65'(body_size);
            state_in = S_H3;
         end
         S_H3: begin
            c4_in  = sum_ff[64] || (sum_ff[63:0] != fsz64);
            h3_in  = 66'({img_height, 1'b0}) + 66'(img_height);
            acc_in = 64'd0;
            ovf_in = 1'b0;
            bit_in = 6'd63;
            state_in = S_MUL;
         end
         S_MUL: begin
            // MSB-first shift-add, one multiplier bit per cycle
            c5a_in = h3_ff[65:64] != 2'b00;
            ovf_in = ovf_ff || acc_ff[63] || add[64];
            acc_in = add[63:0];
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (c1_ff)           res_in.status = ST_SHORT;
            else if (!magic_good) res_in.status = ST_MAGIC;
            else if (c3_ff)      res_in.status = ST_HDR_FILE;
            else if (c4_ff)      res_in.status = ST_TOTAL;
            else if (c5)         res_in.status = ST_CONTENT;
            else if (c6)         res_in.status = ST_TOO_LARGE;
            else                 res_in.status = ST_OK;
            res_in.w3 = w3;
            // offset of the first byte of the bottom row
            res_in.base0 = CW'(body_size[ADDR_W:0]) - w3;
            state_in = S_PROD;
         end
         S_PROD: begin
            res_in.stride = st4;
            state_in = S_IDLE;
            done_in  = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
      // stride is registered here and feeds the product in the next state; PROD keeps using the stored value
      if (state_ff == S_FIN) begin
         res_in.stride = CW'(w3 + CW'(3)) & ~CW'(3);
      end
      if (state_ff == S_PROD) begin
         res_in.total    = 32'(BMP_HDR) + pix_prod[31:0];
         res_in.img_size = {wh_prod[29:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      c1_ff <= c1_in; c3_ff <= c3_in; c4_ff <= c4_in; c5a_ff <= c5a_in;
      sum_ff <= sum_in; h3_ff <= h3_in; acc_ff <= acc_in; ovf_ff <= ovf_in;
      bit_ff <= bit_in; res_ff <= res_in;
   end

   assign busy = (state_ff != S_IDLE) || done_ff;
   assign done = done_ff;
   assign res  = res_ff;

`ifndef SYNTH
   a_done_after_prod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROD) |=> done_ff) else $error("check done missing");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff != S_IDLE) |-> 1'b0) else $error("check restarted while busy");
   a_mul_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && bit_ff == 6'd0) |=> (state_ff == S_FIN))
      else $error("multiply loop overran");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for rgb_image_to_bmp_writer: loads image files byte by byte
// and checks every BMP byte and status against an in-bench predictor. Needs r2b_pkg.
module testbench;
   import r2b_pkg::*;

   localparam int LIMIT = 400000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [2:0] status;
   } bmp_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_func = FUNC_LOAD;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic [2:0] rsp_status;

   // predictor state
   logic [63:0] seen_cnt, hdr_sz, body_sz, img_w, img_h;
   logic        magic_ok;
   logic [2:0]  file_status;
   logic [31:0] emit_pos;
   logic [7:0]  head_mem [HEAD_BYTES];
   logic [7:0]  pixel_mem [int unsigned];

   bmp_byte_type bmp_expected [$];
   int          n_items = 0;
   int          n_errors = 0;
   int          cycles = 0;
   bit          quiet_req = 0;
   bit          quiet_rsp = 0;

   rgb_image_to_bmp_writer DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] row_stride();
      return ((img_w * 3 + 3) / 4) * 4;
   endfunction

   function automatic logic [31:0] bmp_size();
      logic [63:0] t;
      t = 64'd54 + row_stride() * img_h;
      return t[31:0];
   endfunction

   function automatic logic [7:0] bmp_header_at(input logic [31:0] pos);
      logic [7:0]  h [BMP_HDR];
      logic [31:0] tot, isz;
      logic [63:0] p4;
      tot = bmp_size();
      p4 = img_w * img_h * 4;
      isz = p4[31:0];
      foreach (h[i]) h[i] = 8'h00;
      h[0] = 8'h42;
      h[1] = 8'h4d;
      for (int i = 0; i < 4; i++) begin
         h[2 + i]  = tot[8*i +: 8];
         h[10 + i] = 8'(32'd54 >> (8*i));
         h[14 + i] = 8'(32'd40 >> (8*i));
         h[18 + i] = img_w[8*i +: 8];
         h[22 + i] = img_h[8*i +: 8];
         h[34 + i] = isz[8*i +: 8];
         h[38 + i] = 8'(32'd2835 >> (8*i));
         h[42 + i] = 8'(32'd2835 >> (8*i));
      end
      h[26] = 8'd1;
      h[28] = 8'd24;
      return h[pos % BMP_HDR];
   endfunction

   function automatic logic [7:0] content_at(input logic [63:0] k);
      logic [63:0] a;
      a = hdr_sz + k;
      if (a < HEAD_BYTES) return head_mem[a];
      if (k < STORE_BYTES) return pixel_mem.exists(k) ? pixel_mem[k] : 8'h00;
      return 8'h00;
   endfunction

   function automatic logic [7:0] pixel_at(input logic [31:0] pos);
      logic [63:0] s, r, row, col, k;
      s = row_stride();
      if (s == 0 || img_w == 0 || img_h == 0) return 8'h00;
      r = {32'd0, pos} - 64'd54;
      row = r / s;
      col = r % s;
      if (row >= img_h || col >= img_w * 3) return 8'h00;
      k = ((img_h - 1 - row) * img_w + col / 3) * 3 + (2 - col % 3);
      return content_at(k);
   endfunction

   function automatic logic [2:0] file_check(input logic [63:0] len);
      logic [64:0]  sum;
      logic [129:0] prod, wx, hx;
      if (len < MIN_FILE) return ST_SHORT;
      if (!magic_ok) return ST_MAGIC;
      if (hdr_sz > len) return ST_HDR_FILE;
      sum = {1'b0, hdr_sz} + {1'b0, body_sz};
      if (sum[64] || sum[63:0] != len) return ST_TOTAL;
      wx = {66'd0, img_w};
      hx = {66'd0, img_h};
      prod = wx * hx * 130'd3;
      if (img_w != 0 && img_h != 0) begin
         if (prod != {66'd0, body_sz}) return ST_CONTENT;
      end else if (body_sz != 0) return ST_CONTENT;
      if (body_sz > STORE_BYTES || img_w > STORE_BYTES || img_h > STORE_BYTES)
         return ST_TOO_LARGE;
      return ST_OK;
   endfunction

   // advance the predictor by one accepted transaction
   task automatic predict(input logic f, input logic [7:0] d, input logic l);
      logic [63:0] p, v;
      logic [31:0] tot, pos;
      bmp_byte_type e;
      if (f == FUNC_LOAD) begin
         p = seen_cnt;
         if (p == 0) begin
            hdr_sz = 0; body_sz = 0; img_w = 0; img_h = 0;
            magic_ok = 1; file_status = ST_NOT_LOAD; emit_pos = 0;
            foreach (head_mem[i]) head_mem[i] = 8'h00;
         end
         if (p < HEAD_BYTES) begin
            head_mem[p] = d;
            if (p < 4) begin
               if (d != MAGIC_WORD[8*p +: 8]) magic_ok = 0;
            end else begin
               v = {56'd0, d} << (8 * ((p - 4) % 8));
               if (p < 12) hdr_sz |= v;
               else if (p < 20) body_sz |= v;
               else if (p < 28) img_w |= v;
               else img_h |= v;
            end
         end else if (p >= hdr_sz) begin
            if (p - hdr_sz < STORE_BYTES) pixel_mem[p - hdr_sz] = d;
         end
         if (l) begin
            file_status = file_check(p + 1);
            emit_pos = 0;
            seen_cnt = 0;
         end else if (seen_cnt < SEEN_MAX) seen_cnt++;
         return;
      end
      if (file_status != ST_OK) begin
         e = '{data: 8'h00, last: 1'b1, status: file_status};
      end else begin
         tot = bmp_size();
         pos = emit_pos;
         if (pos >= tot) pos = 0;
         e.data = (pos < BMP_HDR) ? bmp_header_at(pos) : pixel_at(pos);
         e.last = (pos + 1 == tot);
         e.status = ST_OK;
         emit_pos = (pos + 1 >= tot) ? 32'd0 : pos + 1;
      end
      bmp_expected = {bmp_expected, e};
   endtask

   // one transaction on the request channel; valid stays up across back-to-back items
   task automatic send_item(input logic f, input logic [7:0] d, input logic l);
      @(negedge clock);
      if (!quiet_req && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 8);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_data_byte <= d;
      req_last_byte <= l;
      do @(posedge clock); while (!req_ready);
      predict(f, d, l);
      n_items++;
   endtask

   task automatic request_bytes(input int n);
      for (int i = 0; i < n; i++) send_item(FUNC_EMIT, 8'($urandom), 1'b0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bmp_expected.size() != 0) @(posedge clock);
   endtask

   // one file: magic, four header words, then random caption and content bytes, optionally with emit requests mixed in
   task automatic load_file(input logic [63:0] hs, input logic [63:0] bs, input logic [63:0] w,
                            input logic [63:0] h, input bit bad_magic, input int len,
                            input bit mix_emits);
      logic [7:0] b;
      int         bad_pos;
      bad_pos = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (i < 4) begin
            b = MAGIC_WORD[8*i +: 8];
            if (bad_magic && i == bad_pos) b = b ^ (8'h01 << $urandom_range(7));
         end else if (i < 12) b = hs[8*(i-4) +: 8];
         else if (i < 20) b = bs[8*(i-12) +: 8];
         else if (i < 28) b = w[8*(i-20) +: 8];
         else if (i < 36) b = h[8*(i-28) +: 8];
         if (mix_emits && $urandom_range(99) < 3)
            send_item(FUNC_EMIT, 8'($urandom), 1'($urandom));
         send_item(FUNC_LOAD, b, i == len - 1);
      end
   endtask

   task automatic good_file(input logic [63:0] w, input logic [63:0] h, input int cap);
      load_file(64'(36 + cap), w * h * 3, w, h, 1'b0, int'(36 + cap + w * h * 3), 1'b0);
   endtask

   task automatic test_unloaded();
      request_bytes(3);
   endtask

   task automatic test_small_images();
      good_file(1, 1, 0);
      request_bytes(60);
      good_file(0, 0, 2);
      request_bytes(56);
      // header overlapping the height field: its upper bytes are content
      load_file(30, 12, 2, 2, 0, 42, 0);
      request_bytes(72);
   endtask

   task automatic test_error_codes();
      load_file(36, 0, 0, 0, 0, 10, 0);
      request_bytes(1);
      load_file(36, 3, 1, 1, 1, 39, 0);
      request_bytes(1);
      load_file(1000, 3, 1, 1, 0, 50, 0);
      request_bytes(1);
      load_file(36, 4, 1, 1, 0, 39, 0);
      request_bytes(1);
      load_file(36, 6, 1, 1, 0, 42, 0);
      request_bytes(1);
      load_file(36, 0, 0, 64'h100_0000_0000, 0, 36 + 2, 0);
      request_bytes(1);
      // sum and product overflow
      load_file(40, 64'hffff_ffff_ffff_ffff, 1, 1, 0, 45, 0);
      request_bytes(1);
      load_file(38, 0, 64'h100_0000_0000, 64'h100_0000_0000, 0, 38, 0);
      request_bytes(2);
   endtask

   task automatic test_drain_pause();
      good_file(2, 1, 1);
      request_bytes(20);
      wait_drained();
      request_bytes(50);
   endtask

   task automatic test_random_files();
      int          kind, cap, len, total;
      logic [63:0] w, h, hs, bs;
      while (n_items < 1550) begin
         if (n_items > 700 && n_items < 1000) quiet_req = 1;
         else quiet_req = 0;
         w = $urandom_range(5);
         h = $urandom_range(4);
         cap = $urandom_range(6);
         hs = 64'(36 + cap);
         bs = w * h * 3;
         len = int'(hs + bs);
         kind = $urandom_range(99);
         if (kind < 70) load_file(hs, bs, w, h, 0, len, kind < 10);
         else if (kind < 75) load_file(hs, bs, w, h, 1, len, 0);
         else if (kind < 82) load_file(hs, bs, w, h, 0, len + ($urandom_range(1) ? 1 : -1), 0);
         else if (kind < 88) load_file(hs, bs + 3, w, h, 0, len + 3, 0);
         else if (kind < 93) load_file(64'(len + 5), bs, w, h, 0, len, 0);
         else load_file({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, 1'($urandom_range(1)), $urandom_range(45), 0);
         total = int'(54 + ((w * 3 + 3) / 4) * 4 * h);
         request_bytes($urandom_range(3) == 0 ? $urandom_range(total) :
                       total + $urandom_range(10));
      end
   endtask

   // rsp side backpressure, driven at the falling edge
   always @(negedge clock) begin
      quiet_rsp <= (n_items > 300 && n_items < 600);
      rsp_ready <= quiet_rsp || ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      bmp_byte_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (bmp_expected.size() == 0) begin
            $display("%0t: unexpected result byte=%h last=%b status=%0d", $time,
                     rsp_out_byte, rsp_out_last, rsp_status);
            n_errors++;
         end else begin
            e = bmp_expected.pop_front();
            if (rsp_out_byte !== e.data || rsp_out_last !== e.last ||
                rsp_status !== e.status) begin
               $display("%0t: mismatch expected byte=%h last=%b status=%0d, actual byte=%h last=%b status=%0d",
                        $time, e.data, e.last, e.status, rsp_out_byte, rsp_out_last, rsp_status);
               n_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      seen_cnt = 0; hdr_sz = 0; body_sz = 0; img_w = 0; img_h = 0;
      magic_ok = 1; file_status = ST_NOT_LOAD; emit_pos = 0;
      foreach (head_mem[i]) head_mem[i] = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_unloaded();
      test_small_images();
      test_error_codes();
      test_drain_pause();
      test_random_files();
      wait_drained();
      repeat (100) @(posedge clock);
      if (n_errors == 0 && bmp_expected.size() == 0) begin
         $display("testbench: clean");
      end else begin
         if (bmp_expected.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, bmp_expected.size());
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/r2b_pkg.sv
rtl/r2b_ram.sv
rtl/r2b_check.sv
rtl/rgb_image_to_bmp_writer.sv
dv/testbench.sv
